// File: hw/rtl/sic_pkg.sv
// Shared types and constants for the substring inversion counter.
`default_nettype none
package sic_pkg;

  localparam int COUNT_W    = 23;
  localparam int POS_W      = 13;
  localparam int LETTER_W   = 6;
  localparam int IN_LET_W   = 5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [POS_W-1:0]    position;
    logic [IN_LET_W-1:0] letter;
    logic [POS_W-1:0]    range_first;
    logic [POS_W-1:0]    range_last;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] inversion_count;
    logic               range_error;
  } out_result_t;

  // Control from the sequencer to the suffix count unit.
  typedef struct packed {
    logic                clear;
    logic                inc;
    logic [LETTER_W-1:0] letter;
  } hist_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/substring_inversion_counter.sv
// Top level of the substring inversion counter: APB register and unit wiring.
//
// A request is taken when start is high and busy is low. A write request
// (opcode 0) stores one letter in its accept cycle and leaves busy low, so
// writes may follow each other on every cycle. A query request (opcode 1)
// walks its range through the letter store, one position per cycle, with a
// single accumulator and a bank of per-letter suffix counts; the store's
// one read port sets that pace. A query keeps busy high while it walks
// its range and through the drain state, in which the last letter read
// is counted. out_valid rises in the first cycle busy is low again, so
// the next request can be taken at the edge that ends the strobe. A
// rejected range strobes out_valid in the cycle right after its accept,
// with range_error set and a count of zero, and busy stays low.
// The result is shown for exactly one cycle; the receiver cannot stall it.
// The APB port holds text_length at byte address 0; write it only while no
// query is running. Synchronous reset returns the sequencer to idle, sets
// text_length to 4096 and clears the suffix counts. The letter store is not
// cleared: positions must be written before a query reads them.
`default_nettype none
module substring_inversion_counter
  import sic_pkg::*;
#(
  parameter int MAX_LEN  = 4096,
  parameter int ALPHABET = 26
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output      logic        busy,
  input  wire in_item_t    in_item,
  output      logic        out_valid,
  output      out_result_t out_result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int AW  = $clog2(MAX_LEN);
  localparam int LTW = $clog2(ALPHABET);
  localparam int CW  = $clog2(MAX_LEN + 1);

  logic [POS_W-1:0] text_length_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [LTW-1:0]   mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [LTW-1:0]   mem_rdata;
  hist_ctl_t        hist_ctl;
  logic [CW-1:0]    gt_count;

  // Only one register exists, so every address selects it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_length_r <= POS_W'(4096);
    end else if (psel && penable && pwrite && pready) begin
      text_length_r <= pwdata[POS_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? 32'(text_length_r) : 32'(text_length_r);

  sic_ctrl #(
    .MAX_LEN  (MAX_LEN),
    .ALPHABET (ALPHABET),
    .AW       (AW),
    .LTW      (LTW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .item        (in_item),
    .text_length (text_length_r),
    .busy        (busy),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .hist_ctl    (hist_ctl),
    .gt_count    (gt_count),
    .out_valid   (out_valid),
    .out_result  (out_result)
  );

  sic_store #(
    .DEPTH (MAX_LEN),
    .AW    (AW),
    .DW    (LTW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sic_suffix #(
    .ALPHABET (ALPHABET),
    .LTW      (LTW),
    .CW       (CW)
  ) u_suffix (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hist_ctl),
    .gt_count (gt_count)
  );

endmodule
`default_nettype wire

// File: hw/rtl/sic_store.sv
// Letter store: one write port and one registered read port.
`default_nettype none
module sic_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 5
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output      logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: hw/rtl/sic_suffix.sv
// Per-letter suffix counts: entry g holds how many walked letters are >= g.
`default_nettype none
module sic_suffix
  import sic_pkg::*;
#(
  parameter int ALPHABET = 26,
  parameter int LTW      = 5,
  parameter int CW       = 13
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire hist_ctl_t     ctl,
  output      logic [CW-1:0] gt_count
);

  logic [CW-1:0]  cnt_r   [ALPHABET];
  logic [CW-1:0]  cnt_nxt [ALPHABET];
  logic [LTW-1:0] lt;

  assign lt = ctl.letter[LTW-1:0];

  // Letters greater than lt are exactly those counted in entry lt+1.
  always_comb begin
    gt_count = '0;
    if (32'(lt) < ALPHABET - 1) begin
      gt_count = cnt_r[LTW'(32'(lt) + 1)];
    end
  end

  always_comb begin
    for (int g = 0; g < ALPHABET; g++) begin
      cnt_nxt[g] = cnt_r[g];
      if (ctl.clear) begin
        cnt_nxt[g] = '0;
      end else if (ctl.inc && (g <= 32'(lt))) begin
        cnt_nxt[g] = cnt_r[g] + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < ALPHABET; g++) begin
      if (!rst_n) begin
        cnt_r[g] <= '0;
      end else begin
        cnt_r[g] <= cnt_nxt[g];
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sic_ctrl.sv
// Sequencer: range check, store walk, shared accumulator and result register.
`default_nettype none
module sic_ctrl
  import sic_pkg::*;
#(
  parameter int MAX_LEN  = 4096,
  parameter int ALPHABET = 26,
  parameter int AW       = 12,
  parameter int LTW      = 5,
  parameter int CW       = 13
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire in_item_t         item,
  input  wire logic [POS_W-1:0] text_length,
  output      logic             busy,
  output      logic             mem_we,
  output      logic [AW-1:0]    mem_waddr,
  output      logic [LTW-1:0]   mem_wdata,
  output      logic             mem_re,
  output      logic [AW-1:0]    mem_raddr,
  input  wire logic [LTW-1:0]   mem_rdata,
  output      hist_ctl_t        hist_ctl,
  input  wire logic [CW-1:0]    gt_count,
  output      logic             out_valid,
  output      out_result_t      out_result
);

  localparam int SUM_W = COUNT_W + 1;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [AW-1:0]      end_r, end_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic               rd_last_r, rd_last_nxt;
  logic [COUNT_W-1:0] acc_r, acc_nxt;
  logic               out_vld_r, out_vld_nxt;
  out_result_t        out_res_r, out_res_nxt;

  logic               accept;
  logic               range_bad;
  logic [LTW-1:0]     cur_letter;
  logic [SUM_W-1:0]   sum;
  logic [COUNT_W-1:0] sum_sat;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign range_bad = (item.range_first == '0) ||
                     (item.range_first > item.range_last) ||
                     (item.range_last > text_length) ||
                     (32'(item.range_last) > MAX_LEN);

  // Writes finish in their accept cycle; bad positions and letters are dropped.
  assign mem_we    = accept && (item.opcode == OP_WRITE) && (item.position != '0) &&
                     (32'(item.position) <= MAX_LEN) && (32'(item.letter) < ALPHABET);
  assign mem_waddr = AW'(item.position - POS_W'(1));
  assign mem_wdata = LTW'(item.letter);

  assign mem_re    = (state_r == ST_WALK);
  assign mem_raddr = addr_r;

  assign cur_letter = (32'(mem_rdata) >= ALPHABET) ? '0 : mem_rdata;

  assign hist_ctl.clear  = accept && (item.opcode == OP_QUERY) && !range_bad;
  assign hist_ctl.inc    = rd_vld_r;
  assign hist_ctl.letter = LETTER_W'(cur_letter);

  // The accumulator saturates and stays saturated.
  assign sum     = SUM_W'(acc_r) + SUM_W'(gt_count);
  assign sum_sat = sum[SUM_W-1] ? '1 : sum[COUNT_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    end_nxt     = end_r;
    rd_vld_nxt  = 1'b0;
    rd_last_nxt = 1'b0;
    acc_nxt     = acc_r;
    out_vld_nxt = 1'b0;
    out_res_nxt = out_res_r;

    if (rd_vld_r) begin
      acc_nxt = sum_sat;
      if (rd_last_r) begin
        out_vld_nxt                 = 1'b1;
        out_res_nxt.inversion_count = sum_sat;
        out_res_nxt.range_error     = 1'b0;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept && (item.opcode == OP_QUERY)) begin
          if (range_bad) begin
            out_vld_nxt                 = 1'b1;
            out_res_nxt.inversion_count = '0;
            out_res_nxt.range_error     = 1'b1;
          end else begin
            addr_nxt  = AW'(item.range_first - POS_W'(1));
            end_nxt   = AW'(item.range_last - POS_W'(1));
            acc_nxt   = '0;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        rd_vld_nxt  = 1'b1;
        rd_last_nxt = (addr_r == end_r);
        if (addr_r == end_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        // The last letter read is being counted in this cycle.
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= rd_vld_nxt;
      rd_last_r <= rd_last_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    end_r     <= end_nxt;
    acc_r     <= acc_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid  = out_vld_r;
  assign out_result = out_res_r;

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !busy)
    else $error("result strobe while a walk is still running");

  a_error_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.range_error) |-> (out_res_r.inversion_count == '0))
    else $error("rejected range carries a nonzero count");

  a_last_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_vld_r && rd_last_r) |=> (out_vld_r && !out_res_r.range_error))
    else $error("last letter of a walk did not produce a result");

  a_good_query_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (item.opcode == OP_QUERY) && !range_bad) |=> (busy && !out_vld_r))
    else $error("accepted query did not start a walk");

  a_read_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_WALK || state_r == ST_DRAIN))
    else $error("store data arrived outside a walk");

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the substring inversion counter.
`timescale 1ns / 100ps
module testbench;
  import sic_pkg::*;

  localparam int MEM_DEPTH = 4096;
  localparam int ALPHA = 26;
  localparam int FILL_LEN = 32;
  localparam int PHASE_ITEMS = 27;
  localparam int POS_MAX = (1 << POS_W) - 1;
  localparam int COUNT_SAT = (1 << COUNT_W) - 1;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] ADDR_TEXT_LENGTH = 2'd0;
  localparam logic ROW_ITEM = 1'b0;
  localparam logic ROW_CFG = 1'b1;

  typedef struct packed {
    logic             kind;
    in_item_t         req;
    logic             typed;
    out_result_t      want;
    logic [POS_W-1:0] cfg_val;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_result_t out_result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: the stored text and the active text length.
  logic [IN_LET_W-1:0] text_mem [1:MEM_DEPTH];
  logic [POS_W-1:0]    text_len_q;
  int unsigned         letter_tally [ALPHA];

  out_result_t pending_counts[$];
  out_result_t oldest_count;
  stim_row_t   plan[$];

  int mismatches;
  int stall_cycles;
  int n_writes;
  int n_ignored;
  int n_queries;
  int n_bad_range;
  int n_results;
  int longest_walk;

  substring_inversion_counter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    end
  endtask

  function automatic void note_expected(out_result_t r);
    pending_counts.insert(pending_counts.size(), r);
  endfunction

  function automatic void add_row(stim_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  function automatic out_result_t count_inversions(int first, int last);
    out_result_t r;
    longint total;
    int usable;
    int c;
    r = '0;
    usable = (int'(text_len_q) > MEM_DEPTH) ? MEM_DEPTH : int'(text_len_q);
    if (first == 0 || first > last || last > usable) begin
      r.range_error = 1'b1;
      return r;
    end
    for (int g = 0; g < ALPHA; g++) letter_tally[g] = 0;
    total = 0;
    // Each position adds the earlier letters in the range that are greater.
    for (int p = first; p <= last; p++) begin
      c = int'(text_mem[p]);
      if (c >= ALPHA) c = 0;
      for (int g = c + 1; g < ALPHA; g++) total += letter_tally[g];
      letter_tally[c]++;
    end
    if (total > COUNT_SAT) total = COUNT_SAT;
    r.inversion_count = total[COUNT_W-1:0];
    return r;
  endfunction

  function automatic bit store_letter(int pos, int ltr);
    if (pos < 1 || pos > MEM_DEPTH || ltr >= ALPHA) return 1'b0;
    text_mem[pos] = ltr[IN_LET_W-1:0];
    return 1'b1;
  endfunction

  task automatic send_request(in_item_t req, int idle_pct, bit typed, out_result_t want);
    int gaps;
    out_result_t pred;
    gaps = 0;
    while (idle_pct > 0 && gaps < 8 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk) start <= 1'b0;
      gaps++;
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
    if (req.opcode == OP_WRITE) begin
      if (store_letter(req.position, req.letter)) n_writes++;
      else n_ignored++;
    end else begin
      pred = count_inversions(req.range_first, req.range_last);
      n_queries++;
      if (pred.range_error) n_bad_range++;
      else if (req.range_last - req.range_first + 1 > longest_walk)
        longest_walk = req.range_last - req.range_first + 1;
      note_expected(typed ? want : pred);
    end
  endtask

  // Lowers start and waits until every query has answered.
  task automatic drain_results();
    @(negedge clk) start <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(bit wr, logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_TEXT_LENGTH;
    pwdata <= wdata;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_text_length();
    logic [31:0] rd;
    apb_access(1'b0, 32'd0, rd);
    if (rd !== {{(32-POS_W){1'b0}}, text_len_q}) report_mismatch("text_length readback", text_len_q, rd);
  endtask

  task automatic set_text_length(int val);
    logic [31:0] rd;
    apb_access(1'b1, val, rd);
    text_len_q = val[POS_W-1:0];
    check_text_length();
  endtask

  function automatic stim_row_t req_row(logic op, int pos, int ltr, int first, int last);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.req.opcode = op;
    r.req.position = pos[POS_W-1:0];
    r.req.letter = ltr[IN_LET_W-1:0];
    r.req.range_first = first[POS_W-1:0];
    r.req.range_last = last[POS_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t wr_row(int pos, int ltr);
    return req_row(OP_WRITE, pos, ltr, 0, 0);
  endfunction

  function automatic stim_row_t q_row(int first, int last);
    return req_row(OP_QUERY, 0, 0, first, last);
  endfunction

  function automatic stim_row_t fixed(stim_row_t r, int cnt, bit err);
    r.typed = 1'b1;
    r.want.inversion_count = cnt[COUNT_W-1:0];
    r.want.range_error = err;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(int val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cfg_val = val[POS_W-1:0];
    return r;
  endfunction

  // Legal queries stay inside the filled prefix of the text.
  function automatic in_item_t random_request();
    in_item_t r;
    int usable;
    int region;
    int pick;
    int span;
    int first;
    int last;
    r.opcode = OP_QUERY;
    r.position = POS_W'($urandom);
    r.letter = IN_LET_W'($urandom);
    r.range_first = POS_W'($urandom);
    r.range_last = POS_W'($urandom);
    usable = (int'(text_len_q) > MEM_DEPTH) ? MEM_DEPTH : int'(text_len_q);
    region = (usable < FILL_LEN) ? usable : FILL_LEN;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      r.opcode = OP_WRITE;
      r.position = POS_W'($urandom_range(0, 1) ? $urandom_range(1, FILL_LEN)
                                               : $urandom_range(1, MEM_DEPTH));
      r.letter = IN_LET_W'($urandom_range(0, ALPHA - 1));
    end else if (pick < 22) begin
      r.opcode = OP_WRITE;
      case ($urandom_range(0, 2))
        0: r.position = '0;
        1: r.position = POS_W'($urandom_range(MEM_DEPTH + 1, POS_MAX));
        default: begin
          r.position = POS_W'($urandom_range(1, MEM_DEPTH));
          r.letter = IN_LET_W'($urandom_range(ALPHA, (1 << IN_LET_W) - 1));
        end
      endcase
    end else if (pick < 30 || region == 0) begin
      case ($urandom_range(0, 2))
        0: r.range_first = '0;
        1: begin
          first = $urandom_range(2, POS_MAX);
          r.range_first = POS_W'(first);
          r.range_last = POS_W'($urandom_range(0, first - 1));
        end
        default: begin
          last = $urandom_range(usable + 1, POS_MAX);
          r.range_last = POS_W'(last);
          r.range_first = POS_W'($urandom_range(1, last));
        end
      endcase
    end else begin
      pick = $urandom_range(0, 99);
      span = $urandom_range(1, region);
      if (pick < 10) begin
        first = 1;
        span = region;
      end else if (pick < 25) begin
        first = region - span + 1;
      end else begin
        first = $urandom_range(1, region - span + 1);
      end
      r.range_first = POS_W'(first);
      r.range_last = POS_W'(first + span - 1);
    end
    return r;
  endfunction

  // Result checking and the no-progress watchdog.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_counts.size() == 0) begin
        report_mismatch("unrequested result, count", -1, out_result.inversion_count);
      end else begin
        oldest_count = pending_counts.pop_front();
        if (out_result.inversion_count !== oldest_count.inversion_count)
          report_mismatch("inversion_count", oldest_count.inversion_count,
                          out_result.inversion_count);
        if (out_result.range_error !== oldest_count.range_error)
          report_mismatch("range_error", oldest_count.range_error, out_result.range_error);
      end
    end
    if ((start && !busy) || out_valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL substring_inversion_counter");
        $finish;
      end
    end
  end

  initial begin
    int idle_pct [3];
    int phase_len [3];
    int pct;
    int ltr;
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_TEXT_LENGTH;
    pwdata = '0;
    mismatches = 0;
    stall_cycles = 0;
    n_writes = 0;
    n_ignored = 0;
    n_queries = 0;
    n_bad_range = 0;
    n_results = 0;
    longest_walk = 0;
    text_len_q = MEM_DEPTH;
    idle_pct = '{0, 45, 17};
    phase_len = '{MEM_DEPTH, $urandom_range(8, FILL_LEN - 1), POS_MAX};

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    check_text_length();

    // Directed part: text edges, ignored writes, rejected ranges, length extremes.
    add_row(wr_row(1, 3));
    add_row(wr_row(2, 1));
    add_row(wr_row(3, 25));
    add_row(wr_row(4, 0));
    add_row(wr_row(5, 2));
    add_row(wr_row(MEM_DEPTH, 25));
    add_row(wr_row(MEM_DEPTH - 1, 0));
    add_row(wr_row(0, 7));
    add_row(wr_row(1, 26));
    add_row(wr_row(2, 31));
    add_row(wr_row(MEM_DEPTH + 1, 5));
    add_row(req_row(OP_WRITE, POS_MAX, 5, POS_MAX, POS_MAX));
    add_row(fixed(q_row(1, 1), 0, 1'b0));
    add_row(q_row(1, 5));
    add_row(fixed(q_row(MEM_DEPTH - 1, MEM_DEPTH), 0, 1'b0));
    add_row(fixed(q_row(MEM_DEPTH, MEM_DEPTH), 0, 1'b0));
    add_row(fixed(q_row(0, 5), 0, 1'b1));
    add_row(fixed(q_row(5, 4), 0, 1'b1));
    add_row(fixed(q_row(1, MEM_DEPTH + 1), 0, 1'b1));
    add_row(fixed(q_row(POS_MAX, POS_MAX), 0, 1'b1));
    add_row(req_row(OP_QUERY, POS_MAX, 31, 1, 3));
    add_row(cfg_row(5));
    add_row(q_row(1, 5));
    add_row(fixed(q_row(1, 6), 0, 1'b1));
    add_row(cfg_row(1));
    add_row(fixed(q_row(1, 1), 0, 1'b0));
    add_row(fixed(q_row(1, 2), 0, 1'b1));
    add_row(cfg_row(0));
    add_row(fixed(q_row(1, 1), 0, 1'b1));
    add_row(cfg_row(POS_MAX));
    add_row(fixed(q_row(MEM_DEPTH, MEM_DEPTH), 0, 1'b0));
    add_row(q_row(MEM_DEPTH - 1, MEM_DEPTH));
    add_row(cfg_row(MEM_DEPTH));
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain_results();
        set_text_length(plan[i].cfg_val);
      end else begin
        send_request(plan[i].req, 0, plan[i].typed, plan[i].want);
      end
    end

    // Fill the start of the text so that any range inside it may be queried.
    // A mostly falling pattern gives the longer ranges large counts.
    for (int pos = 1; pos <= FILL_LEN; pos++) begin
      ltr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ALPHA - 1)
                                          : ((FILL_LEN - pos) * ALPHA) / FILL_LEN;
      send_request(req_row(OP_WRITE, pos, ltr, 0, 0).req, 0, 1'b0, '0);
    end

    for (int ph = 0; ph < 3; ph++) begin
      drain_results();
      set_text_length(phase_len[ph]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 1 && i == 13) drain_results();
        pct = ((i / 8) % 3 == 2) ? 0 : idle_pct[ph];
        send_request(random_request(), pct, 1'b0, '0);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("Run covered %0d letter writes (%0d ignored) and %0d queries, %0d of them rejected.",
             n_writes, n_ignored, n_queries, n_bad_range);
    $display("Longest range walked: %0d positions; %0d results checked over six text lengths.",
             longest_walk, n_results);
    if (mismatches == 0) begin
      $display("PASS substring_inversion_counter");
    end else begin
      $display("FAIL substring_inversion_counter");
    end
    $finish;
  end

endmodule
